[src/hppc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hppc_pkg;

    // One input byte and its sideband flags
    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       to_server;
        logic       end_of_packet;
    } item_t;

    // Sliding byte window, entry 0 oldest, entry 7 newest
    typedef logic [0:7][7:0] win_t;

    localparam int unsigned  WIN_DEPTH  = 8;
    localparam int unsigned  IDX_W      = 4;
    localparam int unsigned  CONF_W     = 7;
    localparam int unsigned  METHOD_CNT = 9;

    localparam logic [IDX_W-1:0] IDX_MAX = 4'd15;
    localparam logic [IDX_W-1:0] POS_METHOD = 4'd3;
    localparam logic [IDX_W-1:0] POS_VER_MIN = 4'd7;
    localparam logic [IDX_W-1:0] POS_STATUS_SP = 4'd8;
    localparam logic [IDX_W-1:0] POS_STATUS_CODE = 4'd11;

    localparam logic [CONF_W-1:0] CONF_NONE = 7'd0;
    localparam logic [CONF_W-1:0] CONF_GOOD = 7'd85;
    localparam logic [CONF_W-1:0] CONF_HIGH = 7'd95;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // "HTTP/1." with the first character in entry 0
    localparam logic [0:6][7:0] VER_TAG = "HTTP/1.";

    // Four-byte request method prefixes, first character in the top byte
    localparam logic [0:METHOD_CNT-1][31:0] METHOD_TAB = {
        "GET ", "POST", "PUT ", "HEAD", "DELE", "OPTI", "PATC", "CONN", "TRAC"
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Window holds "HTTP/1.0" or "HTTP/1.1"
    function automatic logic version_at(input win_t w);
        return (w[0:6] == VER_TAG) && ((w[7] == CH_ZERO) || (w[7] == CH_ONE));
    endfunction

    // Four bytes form one of the method prefixes
    function automatic logic method_hit(input logic [31:0] word);
        logic hit;
        hit = 1'b0;
        for (int m = 0; m < METHOD_CNT; m++)
        begin
            if (word == METHOD_TAB[m])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

[src/http_packet_probe_classifier_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted final byte is held in the input register, then its verdict is loaded
// into the result register and presented on m_tdata.
// One byte per cycle when not stalled; only the final byte of a packet yields a result.
// The input register, the tracker logic and the result register advance together whenever
// the result register is empty or its transfer completes in the same cycle.
// Reset: rst_n is asynchronous and active low; it empties both stages and clears packet state.

module http_packet_probe_classifier_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] pkt_byte
    input  wire logic       s_tuser,   // [0] to_server
    input  wire logic       s_tlast,   // end_of_packet
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [6:0] confidence, [7] zero
);
    import hppc_pkg::*;

    logic              advance;
    logic              item_valid;
    item_t             item;
    logic              step;
    logic [CONF_W-1:0] conf;
    logic              m_tvalid_reg;
    logic [CONF_W-1:0] conf_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign step     = item_valid && advance;

    hppc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .s_tvalid   (s_tvalid),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item)
    );

    hppc_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .conf  (conf)
    );

    // Load a result on each final byte; empty the register once it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= step && item.end_of_packet;
        end
    end

    // Hold the verdict until its transfer
    always_ff @(posedge clk)
    begin
        if (step && item.end_of_packet)
        begin
            conf_reg <= conf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, conf_reg};

endmodule

`default_nettype wire

[src/hppc_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module hppc_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           s_tvalid,
    input  wire logic [7:0]     s_tdata,   // [7:0] pkt_byte
    input  wire logic           s_tuser,   // [0] to_server
    input  wire logic           s_tlast,   // end_of_packet
    output logic                item_valid,
    output hppc_pkg::item_t     item
);
    import hppc_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Capture the transfer whenever the pipeline moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Hold the payload of the accepted transfer
    always_ff @(posedge clk)
    begin
        if (advance && s_tvalid)
        begin
            item_reg <= '{pkt_byte: s_tdata, to_server: s_tuser, end_of_packet: s_tlast};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[src/hppc_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

module hppc_tracker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire hppc_pkg::item_t            item,
    output logic [hppc_pkg::CONF_W-1:0]     conf
);
    import hppc_pkg::*;

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    win_t             win_reg, win_next;
    logic             method_matched_reg, method_matched_next;
    logic             version_pending_reg, version_pending_next;
    logic             version_confirmed_reg, version_confirmed_next;
    logic             status_line_ok_reg, status_line_ok_next;
    logic             status_code_ok_reg, status_code_ok_next;

    logic [7:0]       b;
    logic [IDX_W-1:0] p;
    win_t             win_shift;

    assign b         = item.pkt_byte;
    assign p         = byte_index_reg;
    assign win_shift = {win_reg[1:7], b};

    // Work out the new packet state and the verdict for this byte
    always_comb
    begin
        byte_index_next        = (p < IDX_MAX) ? p + 1'b1 : p;
        win_next               = win_shift;
        method_matched_next    = method_matched_reg;
        status_line_ok_next    = status_line_ok_reg;
        status_code_ok_next    = status_code_ok_reg;
        version_confirmed_next = version_confirmed_reg | version_pending_reg;
        version_pending_next   = (p >= POS_VER_MIN) && version_at(win_shift);
        conf                   = CONF_NONE;

        if ((p == POS_METHOD) && method_hit({win_reg[5], win_reg[6], win_reg[7], b}))
        begin
            method_matched_next = 1'b1;
        end

        if (p == POS_STATUS_SP)
        begin
            status_line_ok_next = version_at(win_reg) && (b == CH_SPACE);
        end

        if ((p == POS_STATUS_CODE) && status_line_ok_reg)
        begin
            status_code_ok_next = (win_reg[6] >= CH_ONE) && (win_reg[6] <= CH_FIVE)
                                  && is_digit(win_reg[7]) && is_digit(b);
        end

        // Pick the verdict by the direction of the final byte
        if (p < POS_METHOD)
        begin
            conf = CONF_NONE;
        end
        else if (!item.to_server)
        begin
            conf = method_matched_next
                   ? (version_confirmed_next ? CONF_HIGH : CONF_GOOD) : CONF_NONE;
        end
        else
        begin
            conf = status_code_ok_next ? CONF_HIGH
                   : (status_line_ok_next ? CONF_GOOD : CONF_NONE);
        end

        // Drop all packet state after the final byte
        if (item.end_of_packet)
        begin
            byte_index_next        = '0;
            win_next               = '0;
            method_matched_next    = 1'b0;
            version_pending_next   = 1'b0;
            version_confirmed_next = 1'b0;
            status_line_ok_next    = 1'b0;
            status_code_ok_next    = 1'b0;
        end
    end

    // Advance the packet state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg        <= '0;
            win_reg               <= '0;
            method_matched_reg    <= 1'b0;
            version_pending_reg   <= 1'b0;
            version_confirmed_reg <= 1'b0;
            status_line_ok_reg    <= 1'b0;
            status_code_ok_reg    <= 1'b0;
        end
        else if (step)
        begin
            byte_index_reg        <= byte_index_next;
            win_reg               <= win_next;
            method_matched_reg    <= method_matched_next;
            version_pending_reg   <= version_pending_next;
            version_confirmed_reg <= version_confirmed_next;
            status_line_ok_reg    <= status_line_ok_next;
            status_code_ok_reg    <= status_code_ok_next;
        end
    end

    // A final byte leaves the tracker at the start of a packet
    a_eop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.end_of_packet) |=> (byte_index_reg == '0) && !method_matched_reg)
        else $error("packet state not cleared after final byte");

    // A status code is only judged after a good status line
    a_code_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        status_code_ok_reg |-> status_line_ok_reg)
        else $error("status code flagged without status line");

    // A method match needs the first four bytes
    a_method_pos: assert property (@(posedge clk) disable iff (!rst_n)
        method_matched_reg |-> (byte_index_reg > POS_METHOD))
        else $error("method match before four bytes");

    // A confirmed version follows at least nine bytes
    a_version_pos: assert property (@(posedge clk) disable iff (!rst_n)
        version_confirmed_reg |-> (byte_index_reg > POS_STATUS_SP))
        else $error("version confirmed too early in packet");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import hppc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BYTES    = 485;

    // Holds the classifier state for the packet in flight and the
    // confidences still owed by the block, oldest first.
    class conf_tracker;
        logic [3:0]  pos;
        logic [63:0] win;      // last eight bytes, newest in the low byte
        logic        req_ok;
        logic        ver_seen;
        logic        ver_next;
        logic        line_ok;
        logic        code_ok;
        logic [6:0]  conf_due[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            pos      = '0;
            win      = '0;
            req_ok   = 1'b0;
            ver_seen = 1'b0;
            ver_next = 1'b0;
            line_ok  = 1'b0;
            code_ok  = 1'b0;
        endfunction

        function bit is_prefix(logic [31:0] w);
            case (w)
                "GET ", "POST", "PUT ", "HEAD", "DELE", "OPTI", "PATC", "CONN", "TRAC":
                    return 1'b1;
                default:
                    return 1'b0;
            endcase
        endfunction

        function bit digit(logic [7:0] c);
            return (c >= "0") && (c <= "9");
        endfunction

        function bit has_version(logic [63:0] w);
            return (w[63:8] == "HTTP/1.") && ((w[7:0] == "0") || (w[7:0] == "1"));
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Advance the packet state by one accepted byte; queue a confidence on the last one
        function void take_byte(logic [7:0] b, logic srv, logic last);
            logic [3:0] p;
            logic [6:0] conf;
            p = pos;
            if (p == 4'd3 && is_prefix({win[23:0], b}))
                req_ok = 1'b1;
            if (p == 4'd8)
                line_ok = has_version(win) && (b == " ");
            if (p == 4'd11 && line_ok)
                code_ok = (win[15:8] >= "1") && (win[15:8] <= "5") && digit(win[7:0]) && digit(b);
            if (ver_next)
                ver_seen = 1'b1;
            win = {win[55:0], b};
            ver_next = (p >= 4'd7) && has_version(win);
            if (pos != 4'd15)
                pos++;
            if (last)
            begin
                if (p < 4'd3)
                    conf = CONF_NONE;
                else if (!srv)
                    conf = req_ok ? (ver_seen ? CONF_HIGH : CONF_GOOD) : CONF_NONE;
                else
                    conf = code_ok ? CONF_HIGH : (line_ok ? CONF_GOOD : CONF_NONE);
                conf_due.push_back(conf);
                clear();
            end
        endfunction

        // Compare one output transfer with the oldest owed confidence
        task match_conf(logic [7:0] data);
            logic [6:0] want;
            if (conf_due.size() == 0)
            begin
                report($sformatf("confidence %0d with no packet end pending", data[6:0]));
                return;
            end
            want = conf_due.pop_front();
            if (data[6:0] !== want)
                report($sformatf("confidence %0d, wanted %0d", data[6:0], want));
            if (data[7] !== 1'b0)
                report("pad bit 7 of m_tdata set");
        endtask
    endclass

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       s_tuser  = 1'b0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    int         gap_pct   = 0;
    int         stall_pct = 0;
    int         sent_bytes = 0;
    int         quiet_cycles = 0;
    logic [7:0] pkt_q[$];
    string      req_names [9] = '{"GET ", "POST", "PUT ", "HEAD", "DELE",
                                   "OPTI", "PATC", "CONN", "TRAC"};

    conf_tracker trk = new();

    http_packet_probe_classifier_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watch both sides for transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                trk.take_byte(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                trk.match_conf(m_tdata);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive one byte, idling first at random, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic srv, input logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= srv;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sent_bytes++;
    endtask

    // Send the staged packet; now and then let the direction wander before the last byte
    task automatic send_packet(input logic srv);
        logic mixed;
        logic d;
        int   i;
        mixed = ($urandom_range(9) == 0);
        for (i = 0; i < pkt_q.size(); i++)
        begin
            d = mixed ? 1'($urandom_range(1)) : srv;
            if (i == pkt_q.size() - 1)
                send_byte(pkt_q[i], srv, 1'b1);
            else
                send_byte(pkt_q[i], d, 1'b0);
        end
    endtask

    task automatic load_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            pkt_q.push_back(s[i]);
    endtask

    task automatic push_noise(input int n, input bit printable);
        repeat (n)
            pkt_q.push_back(printable ? 8'($urandom_range(32, 126)) : 8'($urandom()));
    endtask

    // Version tag, usually with a valid minor digit
    task automatic push_version();
        load_text("HTTP/1.");
        if ($urandom_range(5) == 0)
            pkt_q.push_back(8'($urandom()));
        else
            pkt_q.push_back(8'("0" + $urandom_range(1)));
    endtask

    // Stage one random packet: requests, responses, long and short noise
    task automatic build_packet(output logic srv);
        int  kind;
        int  n;
        int  i;
        kind = $urandom_range(9);
        pkt_q.delete();
        case (kind)
            0:
            begin
                push_noise($urandom_range(1, 4), $urandom_range(1));
                srv = 1'($urandom_range(1));
            end
            1, 2, 3:
            begin
                load_text(req_names[$urandom_range(8)]);
                if ($urandom_range(7) == 0)
                    pkt_q[$urandom_range(3)] = 8'($urandom());
                push_noise($urandom_range(0, 6), $urandom_range(3) != 0);
                if ($urandom_range(3) != 0)
                    push_version();
                push_noise($urandom_range(0, 3), 1'b1);
                srv = ($urandom_range(7) == 0);
            end
            4, 5, 6:
            begin
                load_text("HTTP/1.");
                if ($urandom_range(5) == 0)
                    pkt_q.push_back(8'($urandom()));
                else
                    pkt_q.push_back(8'("0" + $urandom_range(1)));
                pkt_q.push_back(($urandom_range(7) == 0) ? 8'($urandom()) : 8'(" "));
                for (i = 0; i < 3; i++)
                begin
                    if ($urandom_range(7) == 0)
                        pkt_q.push_back(8'($urandom()));
                    else
                        pkt_q.push_back(8'("0" + $urandom_range(i == 0 ? 6 : 9)));
                end
                push_noise($urandom_range(0, 6), 1'b1);
                // cut the response short now and then
                if ($urandom_range(4) == 0)
                begin
                    n = $urandom_range(1, pkt_q.size());
                    while (pkt_q.size() > n)
                        void'(pkt_q.pop_back());
                end
                srv = ($urandom_range(7) != 0);
            end
            7:
            begin
                if ($urandom_range(3) != 0)
                    load_text(req_names[$urandom_range(8)]);
                push_noise($urandom_range(12, 30), $urandom_range(1));
                if ($urandom_range(1))
                    push_version();
                push_noise($urandom_range(0, 2), 1'b1);
                srv = 1'($urandom_range(1));
            end
            default:
            begin
                push_noise($urandom_range(1, 16), 1'b0);
                srv = 1'($urandom_range(1));
            end
        endcase
    endtask

    task automatic send_text(input string s, input logic srv);
        pkt_q.delete();
        load_text(s);
        send_packet(srv);
    endtask

    initial
    begin
        int   ph;
        logic srv;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single extreme bytes, a short request, a bare method, a full status line
        pkt_q.delete();
        pkt_q.push_back(8'hFF);
        send_packet(1'b1);
        pkt_q.delete();
        pkt_q.push_back(8'h00);
        send_packet(1'b0);
        send_text("GET", 1'b0);
        send_text("TRAC", 1'b0);
        send_text("HTTP/1.1 599", 1'b1);

        // Random packets under each idling pattern
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    gap_pct   = 53;
                    stall_pct <= 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct <= 53;
                end
                default:
                begin
                    gap_pct   = 26;
                    stall_pct <= 26;
                end
            endcase
            // hold off until the block has drained
            if (ph != 0)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (trk.conf_due.size() != 0)
                    @(posedge clk);
            end
            while (sent_bytes < 21 + (ph + 1) * PHASE_BYTES)
            begin
                build_packet(srv);
                send_packet(srv);
            end
        end

        // Drain and settle
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (trk.conf_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (trk.conf_due.size() != 0)
            trk.report("confidence still owed at end of run");

        if (trk.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
